/* rtl/core/rms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rms_pkg;

    // Mode codes
    localparam logic [3:0] MODE_IDLE     = 4'd0;
    localparam logic [3:0] MODE_CHARGE   = 4'd5;
    localparam logic [3:0] MODE_NAV      = 4'd2;
    localparam logic [3:0] MODE_EMERG    = 4'd6;
    localparam logic [3:0] MODE_MISSION  = 4'd8;
    localparam logic [3:0] MODE_RECOVER  = 4'd10;
    localparam logic [3:0] MODE_COUNT    = 4'd12;
    localparam logic [3:0] MODE_UNKNOWN  = 4'd12;

    // Event codes
    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_EMERGENCY = 3'd1;
    localparam logic [2:0] ACT_BATTERY   = 3'd2;
    localparam logic [2:0] ACT_COMMAND   = 3'd3;
    localparam logic [2:0] ACT_NAV       = 3'd4;
    localparam logic [2:0] ACT_MISSION   = 3'd5;

    // Status classes
    localparam logic [1:0] NAV_IDLE          = 2'd1;
    localparam logic [1:0] NAV_MISSION       = 2'd2;
    localparam logic [1:0] MISSION_OTHER     = 2'd0;
    localparam logic [1:0] MISSION_COMPLETED = 2'd1;
    localparam logic [1:0] MISSION_FAILED    = 2'd2;

    // Health codes
    localparam logic [2:0] HEALTH_OK       = 3'd0;
    localparam logic [2:0] HEALTH_EMERG    = 3'd1;
    localparam logic [2:0] HEALTH_RECOVER  = 3'd2;
    localparam logic [2:0] HEALTH_CRITICAL = 3'd3;
    localparam logic [2:0] HEALTH_LOW      = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_AUTO_ENABLE    = 3'd0;
    localparam logic [2:0] CFG_CRITICAL_LEVEL = 3'd1;
    localparam logic [2:0] CFG_LOW_LEVEL      = 3'd2;
    localparam logic [2:0] CFG_FULL_LEVEL     = 3'd3;
    localparam logic [2:0] CFG_RECOVERY_TICKS = 3'd4;

    localparam logic [10:0] LEVEL_FULL = 11'd1024;
    localparam logic [15:0] TICKS_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  action;
        logic        emergency_in;
        logic [10:0] battery_in;
        logic [3:0]  cmd_mode;
        logic [1:0]  nav_in;
        logic [1:0]  mission_in;
    } in_t;

    typedef struct packed {
        logic [3:0] mode_now;
        logic [3:0] mode_before;
        logic       moved;
        logic       rejected;
        logic [2:0] health_code;
    } out_t;

    // Row of allowed destinations for each source mode; bit n allows a move to mode n
    function automatic logic [11:0] allowed_row(input logic [3:0] from);
        logic [11:0] row;
        begin
            case (from)
                4'd0:    row = 12'h0FE;
                4'd1:    row = 12'h041;
                4'd2:    row = 12'h561;
                4'd3:    row = 12'h465;
                4'd4:    row = 12'h465;
                4'd5:    row = 12'h841;
                4'd6:    row = 12'h481;
                4'd7:    row = 12'h041;
                4'd8:    row = 12'h645;
                4'd9:    row = 12'h141;
                4'd10:   row = 12'h045;
                4'd11:   row = 12'h061;
                default: row = 12'h000;
            endcase
            return row;
        end
    endfunction

    function automatic logic move_ok(input logic [3:0] from, input logic [3:0] to);
        logic [11:0] row;
        begin
            row = allowed_row(from);
            if (to >= MODE_COUNT)
                return 1'b0;
            return row[to];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/robot_mode_supervisor.sv */
`timescale 1ns / 1ps
`default_nettype none

// Robot mode supervisor.
// Input channel (in_valid / in_stall / in_data) carries one event per transfer:
// tick, emergency flag, battery level, mode command, nav status or mission status.
// Output channel (out_valid / out_stall / out_data) returns exactly one result per
// event: current mode, previous mode, moved / rejected flags and a health code.
// The config port (cfg_we / cfg_index / cfg_data) writes the five thresholds and
// enables; write it only while no event is in flight.
// An event in the input register shows on out_data once it advances into the
// result register. Throughput: one event per cycle while out_stall is low. One
// pass of table lookup and compares updates the mode state and loads the result
// register in the same edge, so the next event already sees the new state.
// When the receiver stalls, the result holds in the output register, the next
// event waits in the input register, and in_stall rises only when both are full.
// Reset puts the block in idle mode with previous mode unknown, battery full,
// nav status idle, mission status other, the tick counter at zero and the
// configuration at its defaults; both channels come up empty.
module robot_mode_supervisor (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire rms_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output rms_pkg::out_t      out_data,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);

    // Configuration
    logic        auto_enable_reg;
    logic [10:0] critical_level_reg;
    logic [10:0] low_level_reg;
    logic [10:0] full_level_reg;
    logic [15:0] recovery_ticks_reg;

    // Supervisor state
    logic [3:0]  mode_reg,     mode_next;
    logic [3:0]  prev_mode_reg, prev_mode_next;
    logic        emergency_reg, emergency_next;
    logic [10:0] battery_reg,  battery_next;
    logic [1:0]  nav_reg,      nav_next;
    logic [1:0]  mission_reg,  mission_next;
    logic [15:0] ticks_reg,    ticks_next;

    // Pipeline registers
    logic          in_valid_reg;
    rms_pkg::in_t  in_reg;
    logic          out_valid_reg;
    rms_pkg::out_t out_reg;
    rms_pkg::out_t result;

    logic advance;

    // Advance the held event whenever the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_enable_reg    <= 1'b1;
            critical_level_reg <= 11'd154;
            low_level_reg      <= 11'd256;
            full_level_reg     <= 11'd922;
            recovery_ticks_reg <= 16'd50;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rms_pkg::CFG_AUTO_ENABLE:    auto_enable_reg    <= cfg_data[0];
                rms_pkg::CFG_CRITICAL_LEVEL: critical_level_reg <= cfg_data[10:0];
                rms_pkg::CFG_LOW_LEVEL:      low_level_reg      <= cfg_data[10:0];
                rms_pkg::CFG_FULL_LEVEL:     full_level_reg     <= cfg_data[10:0];
                rms_pkg::CFG_RECOVERY_TICKS: recovery_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Apply one event to the state and form its result
    always_comb
    begin
        logic [3:0] req_mode;
        logic       req;
        logic [3:0] auto_mode;

        mode_next      = mode_reg;
        prev_mode_next = prev_mode_reg;
        emergency_next = emergency_reg;
        battery_next   = battery_reg;
        nav_next       = nav_reg;
        mission_next   = mission_reg;
        ticks_next     = ticks_reg;
        req            = 1'b0;
        req_mode       = mode_reg;
        auto_mode      = mode_reg;

        case (in_reg.action)
            rms_pkg::ACT_TICK:
            begin
                if (ticks_reg != rms_pkg::TICKS_MAX)
                    ticks_next = ticks_reg + 16'd1;
                // Pick the automatic target in priority order
                if (emergency_reg)
                    auto_mode = rms_pkg::MODE_EMERG;
                else if (battery_reg < critical_level_reg && mode_reg != rms_pkg::MODE_CHARGE)
                    auto_mode = rms_pkg::MODE_CHARGE;
                else
                begin
                    case (mode_reg)
                        rms_pkg::MODE_EMERG:
                            auto_mode = rms_pkg::MODE_RECOVER;
                        rms_pkg::MODE_RECOVER:
                            if (ticks_next > recovery_ticks_reg)
                                auto_mode = rms_pkg::MODE_IDLE;
                        rms_pkg::MODE_CHARGE:
                            if (battery_reg > full_level_reg)
                                auto_mode = rms_pkg::MODE_IDLE;
                        rms_pkg::MODE_NAV:
                            if (nav_reg == rms_pkg::NAV_IDLE)
                                auto_mode = rms_pkg::MODE_IDLE;
                            else if (nav_reg == rms_pkg::NAV_MISSION)
                                auto_mode = rms_pkg::MODE_MISSION;
                        rms_pkg::MODE_MISSION:
                            if (mission_reg == rms_pkg::MISSION_COMPLETED)
                                auto_mode = rms_pkg::MODE_IDLE;
                            else if (mission_reg == rms_pkg::MISSION_FAILED)
                                auto_mode = rms_pkg::MODE_RECOVER;
                        default: ;
                    endcase
                end
                req      = auto_enable_reg && (auto_mode != mode_reg);
                req_mode = auto_mode;
            end
            rms_pkg::ACT_EMERGENCY:
            begin
                emergency_next = in_reg.emergency_in;
                req            = in_reg.emergency_in;
                req_mode       = rms_pkg::MODE_EMERG;
            end
            rms_pkg::ACT_BATTERY:
                battery_next = in_reg.battery_in;
            rms_pkg::ACT_COMMAND:
            begin
                req      = in_reg.cmd_mode < rms_pkg::MODE_COUNT;
                req_mode = in_reg.cmd_mode;
            end
            rms_pkg::ACT_NAV:
                nav_next = in_reg.nav_in;
            rms_pkg::ACT_MISSION:
                mission_next = in_reg.mission_in;
            default: ;
        endcase

        result.moved    = 1'b0;
        result.rejected = 1'b0;
        if (req)
        begin
            if (rms_pkg::move_ok(mode_reg, req_mode))
            begin
                prev_mode_next = mode_reg;
                mode_next      = req_mode;
                ticks_next     = '0;
                result.moved   = 1'b1;
            end
            else
                result.rejected = 1'b1;
        end

        result.mode_now    = mode_next;
        result.mode_before = prev_mode_next;
        // Health reflects the state after the event
        if (mode_next == rms_pkg::MODE_EMERG)
            result.health_code = rms_pkg::HEALTH_EMERG;
        else if (mode_next == rms_pkg::MODE_RECOVER)
            result.health_code = rms_pkg::HEALTH_RECOVER;
        else if (battery_next < critical_level_reg)
            result.health_code = rms_pkg::HEALTH_CRITICAL;
        else if (battery_next < low_level_reg)
            result.health_code = rms_pkg::HEALTH_LOW;
        else
            result.health_code = rms_pkg::HEALTH_OK;
    end

    // State commits only when the event moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= rms_pkg::MODE_IDLE;
            prev_mode_reg <= rms_pkg::MODE_UNKNOWN;
            emergency_reg <= 1'b0;
            battery_reg   <= rms_pkg::LEVEL_FULL;
            nav_reg       <= rms_pkg::NAV_IDLE;
            mission_reg   <= rms_pkg::MISSION_OTHER;
            ticks_reg     <= '0;
        end
        else if (advance)
        begin
            mode_reg      <= mode_next;
            prev_mode_reg <= prev_mode_next;
            emergency_reg <= emergency_next;
            battery_reg   <= battery_next;
            nav_reg       <= nav_next;
            mission_reg   <= mission_next;
            ticks_reg     <= ticks_next;
        end
    end

    // Input register: load a new event when empty or when the held one advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_reg <= in_data;
    end

    // Result register: hold while stalled, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.moved && out_reg.rejected))
        else $error("moved and rejected both set");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.mode_now < rms_pkg::MODE_COUNT))
        else $error("mode out of range");

    a_move_changes_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.moved) |-> (out_reg.mode_before != out_reg.mode_now))
        else $error("move left mode unchanged");

    a_move_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.moved) |=> (ticks_reg == 16'd0))
        else $error("tick counter not cleared on move");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && !advance) |=> $stable(out_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

/* tb/tb_robot_mode_supervisor.sv */
`timescale 1ns / 1ps

module tb_robot_mode_supervisor;

    // Codes the package does not name
    localparam logic [3:0] MODE_DOCK     = 4'd11;
    localparam logic [2:0] ACT_SPARE_LO  = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI  = 3'd7;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int HOLD_CYCLES     = 60;

    // Allowed destinations per source mode, bit n of row m allows m -> n.
    // Row 0 sits in the low bits, so the list runs from mode 11 down to mode 0.
    localparam logic [11:0][11:0] MOVE_ROWS = {
        12'h061, 12'h045, 12'h141, 12'h645, 12'h041, 12'h481,
        12'h841, 12'h465, 12'h465, 12'h561, 12'h041, 12'h0FE
    };

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    rms_pkg::in_t   in_data;
    logic           out_valid;
    logic           out_stall;
    rms_pkg::out_t  out_data;
    logic           cfg_we;
    logic  [2:0]    cfg_index;
    logic  [15:0]   cfg_data;

    // Mirror of the supervisor: settings
    logic        auto_on     = 1'b1;
    logic [10:0] crit_lvl    = 11'd154;
    logic [10:0] low_lvl     = 11'd256;
    logic [10:0] full_lvl    = 11'd922;
    logic [15:0] recov_limit = 16'd50;

    // Mirror of the supervisor: mode state
    logic [3:0]  mode_cur    = rms_pkg::MODE_IDLE;
    logic [3:0]  mode_prev   = rms_pkg::MODE_UNKNOWN;
    logic        estop_seen  = 1'b0;
    logic [10:0] batt_lvl    = rms_pkg::LEVEL_FULL;
    logic [1:0]  nav_st      = rms_pkg::NAV_IDLE;
    logic [1:0]  msn_st      = rms_pkg::MISSION_OTHER;
    logic [15:0] dwell_ticks = 16'd0;

    rms_pkg::out_t pending_reports[$];
    int   mismatch_count = 0;
    logic calm = 1'b0;
    logic hold_req = 1'b0;

    typedef struct {
        rms_pkg::in_t  ev;
        logic          typed;
        rms_pkg::out_t want;
    } probe_t;

    probe_t probes[$];

    robot_mode_supervisor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Move the mirrored mode if the table allows it, else flag the refusal
    function automatic void try_move(input logic [3:0] dest, inout logic moved,
                                     inout logic refused);
        if (dest < rms_pkg::MODE_COUNT && MOVE_ROWS[mode_cur][dest])
        begin
            mode_prev   = mode_cur;
            mode_cur    = dest;
            dwell_ticks = 16'd0;
            moved       = 1'b1;
        end
        else
        begin
            refused = 1'b1;
        end
    endfunction

    // Apply one event to the mirrored state and return the report it produces
    function automatic rms_pkg::out_t next_mode_report(input rms_pkg::in_t ev);
        rms_pkg::out_t rep;
        logic [3:0]    goal;
        logic          moved;
        logic          refused;
        moved   = 1'b0;
        refused = 1'b0;
        case (ev.action)
            rms_pkg::ACT_TICK:
            begin
                if (dwell_ticks != rms_pkg::TICKS_MAX)
                    dwell_ticks = dwell_ticks + 16'd1;
                if (auto_on)
                begin
                    // Priority: emergency, critical battery, then the per-mode rules
                    goal = mode_cur;
                    if (estop_seen)
                        goal = rms_pkg::MODE_EMERG;
                    else if (batt_lvl < crit_lvl && mode_cur != rms_pkg::MODE_CHARGE)
                        goal = rms_pkg::MODE_CHARGE;
                    else
                    begin
                        case (mode_cur)
                            rms_pkg::MODE_EMERG:
                                goal = rms_pkg::MODE_RECOVER;
                            rms_pkg::MODE_RECOVER:
                                if (dwell_ticks > recov_limit)
                                    goal = rms_pkg::MODE_IDLE;
                            rms_pkg::MODE_CHARGE:
                                if (batt_lvl > full_lvl)
                                    goal = rms_pkg::MODE_IDLE;
                            rms_pkg::MODE_NAV:
                            begin
                                if (nav_st == rms_pkg::NAV_IDLE)
                                    goal = rms_pkg::MODE_IDLE;
                                else if (nav_st == rms_pkg::NAV_MISSION)
                                    goal = rms_pkg::MODE_MISSION;
                            end
                            rms_pkg::MODE_MISSION:
                            begin
                                if (msn_st == rms_pkg::MISSION_COMPLETED)
                                    goal = rms_pkg::MODE_IDLE;
                                else if (msn_st == rms_pkg::MISSION_FAILED)
                                    goal = rms_pkg::MODE_RECOVER;
                            end
                            default:
                                ;
                        endcase
                    end
                    if (goal != mode_cur)
                        try_move(goal, moved, refused);
                end
            end
            rms_pkg::ACT_EMERGENCY:
            begin
                // A set flag always asks for emergency, even from emergency itself
                estop_seen = ev.emergency_in;
                if (estop_seen)
                    try_move(rms_pkg::MODE_EMERG, moved, refused);
            end
            rms_pkg::ACT_BATTERY:
                batt_lvl = ev.battery_in;
            rms_pkg::ACT_COMMAND:
                if (ev.cmd_mode < rms_pkg::MODE_COUNT)
                    try_move(ev.cmd_mode, moved, refused);
            rms_pkg::ACT_NAV:
                nav_st = ev.nav_in;
            rms_pkg::ACT_MISSION:
                msn_st = ev.mission_in;
            default:
                ;
        endcase
        rep.mode_now    = mode_cur;
        rep.mode_before = mode_prev;
        rep.moved       = moved;
        rep.rejected    = refused;
        if (mode_cur == rms_pkg::MODE_EMERG)
            rep.health_code = rms_pkg::HEALTH_EMERG;
        else if (mode_cur == rms_pkg::MODE_RECOVER)
            rep.health_code = rms_pkg::HEALTH_RECOVER;
        else if (batt_lvl < crit_lvl)
            rep.health_code = rms_pkg::HEALTH_CRITICAL;
        else if (batt_lvl < low_lvl)
            rep.health_code = rms_pkg::HEALTH_LOW;
        else
            rep.health_code = rms_pkg::HEALTH_OK;
        return rep;
    endfunction

    function automatic rms_pkg::in_t ev_of(input logic [2:0] act, input logic e,
                                           input logic [10:0] b, input logic [3:0] t,
                                           input logic [1:0] n, input logic [1:0] m);
        rms_pkg::in_t ev;
        ev.action       = act;
        ev.emergency_in = e;
        ev.battery_in   = b;
        ev.cmd_mode     = t;
        ev.nav_in       = n;
        ev.mission_in   = m;
        return ev;
    endfunction

    function automatic rms_pkg::out_t rep_of(input logic [3:0] now, input logic [3:0] prev,
                                             input logic moved, input logic refused,
                                             input logic [2:0] health);
        rms_pkg::out_t rep;
        rep.mode_now    = now;
        rep.mode_before = prev;
        rep.moved       = moved;
        rep.rejected    = refused;
        rep.health_code = health;
        return rep;
    endfunction

    // Append one row to the directed table
    function automatic void add_probe(input rms_pkg::in_t ev, input logic typed,
                                      input rms_pkg::out_t want);
        probe_t pr;
        pr.ev    = ev;
        pr.typed = typed;
        pr.want  = want;
        probes.insert(probes.size(), pr);
    endfunction

    // Random event, partly steering the robot along mission flows from its current mode
    function automatic rms_pkg::in_t random_event();
        rms_pkg::in_t ev;
        logic [31:0]  raw;
        int           pick;
        raw  = $urandom;
        ev   = raw[$bits(rms_pkg::in_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            ev.action = rms_pkg::ACT_TICK;
        end
        else if (pick < 48)
        begin
            ev.action       = rms_pkg::ACT_EMERGENCY;
            ev.emergency_in = ($urandom_range(0, 3) == 0);
        end
        else if (pick < 58)
        begin
            ev.action = rms_pkg::ACT_BATTERY;
            if ($urandom_range(0, 7) == 0)
                ev.battery_in = raw[30:20];
            else
                ev.battery_in = 11'($urandom_range(0, rms_pkg::LEVEL_FULL));
        end
        else if (pick < 75)
        begin
            ev.action = rms_pkg::ACT_COMMAND;
            if ($urandom_range(0, 9) == 0)
                ev.cmd_mode = 4'($urandom_range(rms_pkg::MODE_UNKNOWN, 15));
            else
                ev.cmd_mode = 4'($urandom_range(0, rms_pkg::MODE_COUNT - 1));
        end
        else if (pick < 94)
        begin
            case (mode_cur)
                rms_pkg::MODE_NAV:
                    ev.action = rms_pkg::ACT_NAV;
                rms_pkg::MODE_MISSION:
                    ev.action = rms_pkg::ACT_MISSION;
                rms_pkg::MODE_CHARGE:
                begin
                    ev.action     = rms_pkg::ACT_BATTERY;
                    ev.battery_in = 11'($urandom_range(0, rms_pkg::LEVEL_FULL));
                end
                default:
                begin
                    ev.action   = rms_pkg::ACT_COMMAND;
                    ev.cmd_mode = (mode_cur == rms_pkg::MODE_IDLE) ?
                                  rms_pkg::MODE_NAV : rms_pkg::MODE_IDLE;
                end
            endcase
        end
        else if (pick < 97)
        begin
            ev.action = raw[31] ? rms_pkg::ACT_NAV : rms_pkg::ACT_MISSION;
        end
        else
        begin
            ev.action = raw[31] ? ACT_SPARE_LO : ACT_SPARE_HI;
        end
        return ev;
    endfunction

    // Offer one event, wait for its transfer, then file the expected report
    task automatic push_event(input rms_pkg::in_t ev, input logic typed,
                              input rms_pkg::out_t want);
        rms_pkg::out_t predicted;
        int            gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= ev;
        do
            @(posedge clk);
        while (in_stall);
        // Advance the mirror even where the report is typed in by hand
        predicted = next_mode_report(ev);
        pending_reports.insert(pending_reports.size(), typed ? want : predicted);
    endtask

    // Drop valid and hold until every report is back and the block is quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all five registers back to back, then lower the write enable
    task automatic set_config(input logic en, input logic [10:0] crit,
                              input logic [10:0] low, input logic [10:0] full,
                              input logic [15:0] recov);
        logic [15:0] vals [5];
        logic [2:0]  idxs [5];
        int          i;
        vals = '{{15'd0, en}, {5'd0, crit}, {5'd0, low}, {5'd0, full}, recov};
        idxs = '{rms_pkg::CFG_AUTO_ENABLE, rms_pkg::CFG_CRITICAL_LEVEL,
                 rms_pkg::CFG_LOW_LEVEL, rms_pkg::CFG_FULL_LEVEL,
                 rms_pkg::CFG_RECOVERY_TICKS};
        for (i = 0; i < 5; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        auto_on     = en;
        crit_lvl    = crit;
        low_lvl     = low;
        full_lvl    = full;
        recov_limit = recov;
    endtask

    function automatic int field_bad(input string name, input logic [3:0] want,
                                     input logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Receiver: random stall bursts, one long hold-off on request, none when calm
    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // Hold long enough for the input register to fill and stall the sender
                out_stall <= 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each report transfer with the oldest expectation
    always @(posedge clk)
    begin : report_check
        rms_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t ns: report %h arrived with none expected", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                mismatch_count += field_bad("mode_now", want.mode_now, out_data.mode_now);
                mismatch_count += field_bad("mode_before", want.mode_before,
                                            out_data.mode_before);
                mismatch_count += field_bad("moved", want.moved, out_data.moved);
                mismatch_count += field_bad("rejected", want.rejected, out_data.rejected);
                mismatch_count += field_bad("health_code", want.health_code,
                                            out_data.health_code);
            end
        end
    end

    initial
    begin : watchdog
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int           p;
        int           sent;
        rms_pkg::in_t ev;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk from reset: ignored events, self and unknown commands,
        // the nav to mission to recover flow, emergency entry and repeat, the
        // critical and low battery, over-range battery and the charged return.
        add_probe(ev_of(rms_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b1,
                  rep_of(rms_pkg::MODE_IDLE, rms_pkg::MODE_UNKNOWN, 0, 0,
                         rms_pkg::HEALTH_OK));
        add_probe(ev_of(rms_pkg::ACT_COMMAND, 0, 0, rms_pkg::MODE_UNKNOWN, 0, 0), 1'b1,
                  rep_of(rms_pkg::MODE_IDLE, rms_pkg::MODE_UNKNOWN, 0, 0,
                         rms_pkg::HEALTH_OK));
        add_probe(ev_of(rms_pkg::ACT_COMMAND, 0, 0, rms_pkg::MODE_IDLE, 0, 0), 1'b1,
                  rep_of(rms_pkg::MODE_IDLE, rms_pkg::MODE_UNKNOWN, 0, 1,
                         rms_pkg::HEALTH_OK));
        add_probe(ev_of(ACT_SPARE_LO, 1, 11'h7FF, 4'hF, 2'd3, 2'd3), 1'b1,
                  rep_of(rms_pkg::MODE_IDLE, rms_pkg::MODE_UNKNOWN, 0, 0,
                         rms_pkg::HEALTH_OK));
        add_probe(ev_of(ACT_SPARE_HI, 1, 11'h7FF, 4'hF, 2'd3, 2'd3), 1'b1,
                  rep_of(rms_pkg::MODE_IDLE, rms_pkg::MODE_UNKNOWN, 0, 0,
                         rms_pkg::HEALTH_OK));
        add_probe(ev_of(rms_pkg::ACT_COMMAND, 0, 0, rms_pkg::MODE_NAV, 0, 0), 1'b1,
                  rep_of(rms_pkg::MODE_NAV, rms_pkg::MODE_IDLE, 1, 0,
                         rms_pkg::HEALTH_OK));
        add_probe(ev_of(rms_pkg::ACT_NAV, 0, 0, 0, rms_pkg::NAV_MISSION, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_MISSION, 0, 0, 0, 0, rms_pkg::MISSION_FAILED),
                  1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_BATTERY, 0, 0, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_EMERGENCY, 1, 0, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_EMERGENCY, 1, 0, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_EMERGENCY, 0, 0, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_BATTERY, 0, rms_pkg::LEVEL_FULL, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_COMMAND, 0, 0, 4'hF, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_COMMAND, 0, 0, MODE_DOCK, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_COMMAND, 0, 0, rms_pkg::MODE_IDLE, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_COMMAND, 0, 0, rms_pkg::MODE_CHARGE, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_BATTERY, 0, 11'd200, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_BATTERY, 0, 11'd100, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_BATTERY, 0, 11'h7FF, 0, 0, 0), 1'b0, '0);
        add_probe(ev_of(rms_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b0, '0);
        foreach (probes[i])
            push_event(probes[i].ev, probes[i].typed, probes[i].want);
        settle();

        // Random phases, each under its own settings; the last one runs calm
        for (p = 0; p < NUM_PHASES; p++)
        begin
            calm = (p == NUM_PHASES - 1);
            case (p)
                0: set_config(1'b1, 11'd154, 11'd256, 11'd922, 16'd50);
                1: set_config(1'b1, 11'd0, 11'd0, 11'd0, 16'd0);
                2: set_config(1'b1, rms_pkg::LEVEL_FULL, rms_pkg::LEVEL_FULL,
                              rms_pkg::LEVEL_FULL, rms_pkg::TICKS_MAX);
                3: set_config(1'b0, 11'd300, 11'd500, 11'd700, 16'd3);
                4: set_config(1'b1, 11'($urandom_range(0, rms_pkg::LEVEL_FULL)),
                              11'($urandom_range(0, rms_pkg::LEVEL_FULL)),
                              11'($urandom_range(0, rms_pkg::LEVEL_FULL)),
                              16'($urandom_range(0, 20)));
                default: set_config(1'b1, 11'd154, 11'd256, 11'd922, 16'd5);
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                ev = random_event();
                push_event(ev, 1'b0, '0);
                if (ev.action < ACT_SPARE_LO)
                begin
                    sent++;
                    // Long receiver hold-off while events keep coming
                    if (p == 1 && sent == 40)
                        hold_req = 1'b1;
                    // Sender pause until the block has drained
                    if (p == 2 && sent == 100)
                        settle();
                end
            end
            settle();
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/rms_pkg.sv
rtl/core/robot_mode_supervisor.sv
tb/tb_robot_mode_supervisor.sv
